// ===== rtl/core/qdbq_pkg.sv =====
// ----------------------------------------------------------------------------
// qdbq_pkg
// Types, register codes and the quadrature transition table for the
// detent and button qualifier.
// ----------------------------------------------------------------------------
package qdbq_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 10;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [CFG_DATA_WIDTH-1:0]  cfg_data_t;

    localparam cfg_index_t CFG_LOCKOUT_MS       = 2'd0;
    localparam cfg_index_t CFG_STEPS_PER_DETENT = 2'd1;

    localparam logic [9:0] LOCKOUT_MS_RST       = 10'd120;
    localparam logic [2:0] STEPS_PER_DETENT_RST = 3'd4;

    // indexed by {old phase, new phase}, phase = {A, B}
    localparam logic signed [1:0] STEP_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    typedef struct packed {
        logic        phase_a;
        logic        phase_b;
        logic        back_in;
        logic        confirm_in;
        logic [31:0] time_ms;
    } in_t;

    typedef struct packed {
        logic signed [1:0]  detent_step;
        logic signed [31:0] position;
        logic               back_event;
        logic               confirm_event;
        logic [15:0]        back_count;
        logic [15:0]        confirm_count;
        logic               press_held;
    } out_t;

endpackage

// ===== rtl/core/quadrature_detent_and_button_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// quadrature_detent_and_button_qualifier_core
// Quadrature detent decoder with lockout-qualified back and confirm buttons.
// ----------------------------------------------------------------------------
// Each accepted poll sample gives exactly one result transaction, registered
// in the cycle after acceptance. A new sample is taken every cycle while the
// result register is empty or being drained, so the sustained rate is one
// sample per clock; it is bounded only by the single result register and the
// downstream ready. The first sample after reset just records the encoder
// phase. Phase changes walk a 16-entry transition table into a small signed
// accumulator; reaching +/- steps_per_detent (0 acts as 1) emits a detent step
// and moves the wrapping position. Button falling edges count as presses
// unless they arrive within lockout_ms of the last accepted press (time taken
// modulo 2^TIME_WIDTH), in which case the levels are not stored and the edge
// is retried on later samples. Back wins when both buttons fall together.
// Configuration writes take effect on the next accepted sample.
// ----------------------------------------------------------------------------
module quadrature_detent_and_button_qualifier_core #(
    parameter int TIME_WIDTH  = qdbq_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = qdbq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config
    input  logic                 cfg_we,
    input  qdbq_pkg::cfg_index_t cfg_index,
    input  qdbq_pkg::cfg_data_t  cfg_data,
    // samples in
    input  logic                 s_valid,
    output logic                 s_ready,
    input  qdbq_pkg::in_t        s_data,
    // results out
    output logic                 m_valid,
    input  logic                 m_ready,
    output qdbq_pkg::out_t       m_data
);

    // configuration registers
    logic [9:0] lockout_ms_reg;
    logic [2:0] steps_per_detent_reg;

    // decoder state
    logic [1:0]             prev_phase_reg,      prev_phase_next;
    logic                   phase_valid_reg,     phase_valid_next;
    logic signed [3:0]      step_accum_reg,      step_accum_next;
    logic [31:0]            position_reg,        position_next;
    logic                   back_prev_reg,       back_prev_next;
    logic                   confirm_prev_reg,    confirm_prev_next;
    logic [TIME_WIDTH-1:0]  last_press_reg,      last_press_next;
    logic [COUNT_WIDTH-1:0] back_total_reg,      back_total_next;
    logic [COUNT_WIDTH-1:0] confirm_total_reg,   confirm_total_next;

    // result register
    logic                   m_valid_reg;
    qdbq_pkg::out_t         m_data_reg,          m_data_next;

    logic                   s_accept;
    logic [1:0]             phase;
    logic signed [1:0]      table_step;
    logic signed [3:0]      accum_sum;
    logic signed [3:0]      limit;
    logic [TIME_WIDTH-1:0]  now_t;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic                   back_fall;
    logic                   confirm_fall;
    logic                   locked;
    logic signed [1:0]      step;
    logic                   back_ev;
    logic                   confirm_ev;

    // Output register frees up when drained, so a sample enters every cycle
    // under steady flow.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign phase      = {s_data.phase_a, s_data.phase_b};
    assign table_step = qdbq_pkg::STEP_TABLE[{prev_phase_reg, phase}];
    // accumulator sits within +/-6 between samples, so +/-1 never overflows
    assign accum_sum  = step_accum_reg + {{2{table_step[1]}}, table_step};
    assign limit      = (steps_per_detent_reg == 3'd0) ? 4'sd1
                                                       : {1'b0, steps_per_detent_reg};

    assign now_t   = TIME_WIDTH'(s_data.time_ms);
    assign elapsed = now_t - last_press_reg;

    assign back_fall    = back_prev_reg && !s_data.back_in;
    assign confirm_fall = confirm_prev_reg && !s_data.confirm_in;
    assign locked       = (back_fall || confirm_fall) &&
                          (elapsed < TIME_WIDTH'(lockout_ms_reg));

    // --- encoder path ---
    always_comb begin
        prev_phase_next  = prev_phase_reg;
        phase_valid_next = 1'b1;
        step_accum_next  = step_accum_reg;
        position_next    = position_reg;
        step             = 2'sd0;
        if (!phase_valid_reg) begin
            prev_phase_next = phase;
        end else if (phase != prev_phase_reg) begin
            prev_phase_next = phase;
            step_accum_next = accum_sum;
            if (accum_sum >= limit) begin
                step            = 2'sd1;
                position_next   = position_reg + 32'd1;
                step_accum_next = 4'sd0;
            end else if (accum_sum <= -limit) begin
                step            = -2'sd1;
                position_next   = position_reg - 32'd1;
                step_accum_next = 4'sd0;
            end
        end
    end

    // --- button path ---
    always_comb begin
        back_prev_next     = back_prev_reg;
        confirm_prev_next  = confirm_prev_reg;
        last_press_next    = last_press_reg;
        back_total_next    = back_total_reg;
        confirm_total_next = confirm_total_reg;
        back_ev            = 1'b0;
        confirm_ev         = 1'b0;
        if (!locked) begin
            back_prev_next    = s_data.back_in;
            confirm_prev_next = s_data.confirm_in;
            // back takes priority; a simultaneous confirm edge is dropped
            if (back_fall) begin
                back_total_next = back_total_reg + 1'b1;
                back_ev         = 1'b1;
                last_press_next = now_t;
            end else if (confirm_fall) begin
                confirm_total_next = confirm_total_reg + 1'b1;
                confirm_ev         = 1'b1;
                last_press_next    = now_t;
            end
        end
    end

    always_comb begin
        m_data_next.detent_step   = step;
        m_data_next.position      = position_next;
        m_data_next.back_event    = back_ev;
        m_data_next.confirm_event = confirm_ev;
        m_data_next.back_count    = 16'(back_total_next);
        m_data_next.confirm_count = 16'(confirm_total_next);
        m_data_next.press_held    = locked;
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lockout_ms_reg       <= qdbq_pkg::LOCKOUT_MS_RST;
            steps_per_detent_reg <= qdbq_pkg::STEPS_PER_DETENT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                qdbq_pkg::CFG_LOCKOUT_MS:       lockout_ms_reg       <= cfg_data;
                qdbq_pkg::CFG_STEPS_PER_DETENT: steps_per_detent_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // state update on every accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_phase_reg    <= 2'b00;
            phase_valid_reg   <= 1'b0;
            step_accum_reg    <= 4'sd0;
            position_reg      <= 32'd0;
            back_prev_reg     <= 1'b1;
            confirm_prev_reg  <= 1'b1;
            last_press_reg    <= '0;
            back_total_reg    <= '0;
            confirm_total_reg <= '0;
        end else if (s_accept) begin
            prev_phase_reg    <= prev_phase_next;
            phase_valid_reg   <= phase_valid_next;
            step_accum_reg    <= step_accum_next;
            position_reg      <= position_next;
            back_prev_reg     <= back_prev_next;
            confirm_prev_reg  <= confirm_prev_next;
            last_press_reg    <= last_press_next;
            back_total_reg    <= back_total_next;
            confirm_total_reg <= confirm_total_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== rtl/core/qdbq_checker.sv =====
// ----------------------------------------------------------------------------
// qdbq_checker
// Port-level checks for the detent and button qualifier, bound to the core.
// ----------------------------------------------------------------------------
module qdbq_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input qdbq_pkg::out_t       m_data
);

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // an empty output stage never backpressures
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    // back priority: one press per sample at most
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.back_event && m_data.confirm_event))
        else $error("two presses accepted in one sample");

    // a held press gives no event
    a_held_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.press_held |-> !m_data.back_event && !m_data.confirm_event)
        else $error("event reported on a held press");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.detent_step != 2'b10)
        else $error("detent step out of range");

endmodule

bind quadrature_detent_and_button_qualifier_core qdbq_checker u_qdbq_checker (.*);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quadrature detent and button qualifier core.
// ----------------------------------------------------------------------------
// Poll samples go in over the s_ handshake in random bursts. Each accepted
// transaction is run through a local model of the decoder and the lockout
// qualifier, and the report it should give is queued. A monitor pops the
// queue for every report transaction and compares it field by field.
// Directed tests cover the opening sample, the lockout edges, both buttons
// falling, time wrap and the register extremes. A long output stall checks
// input back-pressure, and a random soak runs under several register
// settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF                = 4;
    localparam int CYCLE_LIMIT             = 500000;
    localparam int HOLD_OFF_CYCLES         = 200;
    localparam int SETTLE_CYCLES           = 4;
    localparam int RANDOM_POLLS_PER_SETTING = 160;
    localparam int BACKPRESSURE_POLLS      = 40;

    // receiver behaviour, one per stretch of the run
    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    qdbq_pkg::cfg_index_t cfg_index = '0;
    qdbq_pkg::cfg_data_t  cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    qdbq_pkg::in_t        s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    qdbq_pkg::out_t       m_data;

    quadrature_detent_and_button_qualifier_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Local model state: encoder tracking, button qualifier and registers
    // ------------------------------------------------------------------------
    logic [1:0]  enc_prev;
    logic        enc_seen;
    int          step_sum;
    logic [31:0] detent_pos;
    logic        back_lvl_q;
    logic        confirm_lvl_q;
    logic [31:0] last_accept_ms;
    logic [15:0] back_hits;
    logic [15:0] confirm_hits;
    logic [9:0]  lockout_reg;
    logic [2:0]  detent_reg;

    // reports still owed by the block, oldest first
    qdbq_pkg::out_t pending_reports [$];
    int          mismatches = 0;

    // sender burst control
    int          burst_left = 0;
    bit          gaps_on    = 1'b1;

    // receiver control: the stimulus raises hold_requests, the receiver
    // process counts the stall out on its own
    rx_mode_t    rx_mode        = RX_ALWAYS;
    int          hold_requests  = 0;
    int          holds_started  = 0;
    int          hold_left      = 0;
    int          rx_tick        = 0;
    int          cycle_count    = 0;

    // random stimulus state, kept between polls so rotation stays coherent
    logic [1:0]  stim_phase   = 2'b00;
    bit          spin_cw      = 1'b1;
    logic        stim_back    = 1'b1;
    logic        stim_confirm = 1'b1;
    logic [31:0] stim_ms      = '0;

    // Clockwise walk of the {A,B} phase is 00 -> 10 -> 11 -> 01 -> 00
    function automatic logic [1:0] cw_next(logic [1:0] ph);
        case (ph)
            2'b00:   return 2'b10;
            2'b10:   return 2'b11;
            2'b11:   return 2'b01;
            default: return 2'b00;
        endcase
    endfunction

    function automatic logic [1:0] ccw_next(logic [1:0] ph);
        case (ph)
            2'b00:   return 2'b01;
            2'b01:   return 2'b11;
            2'b11:   return 2'b10;
            default: return 2'b00;
        endcase
    endfunction

    function automatic void reset_qualifier_model();
        enc_prev        = 2'b00;
        enc_seen        = 1'b0;
        step_sum        = 0;
        detent_pos      = '0;
        back_lvl_q      = 1'b1;
        confirm_lvl_q   = 1'b1;
        last_accept_ms  = '0;
        back_hits       = '0;
        confirm_hits    = '0;
        lockout_reg     = 10'd120;
        detent_reg      = 3'd4;
    endfunction

    // Advances the model by one poll and returns the report it should give
    function automatic qdbq_pkg::out_t qualify_sample(qdbq_pkg::in_t smp);
        qdbq_pkg::out_t res;
        logic [1:0]  ph;
        int          limit;
        logic        back_fall;
        logic        confirm_fall;
        logic [31:0] elapsed;
        res   = '0;
        ph    = {smp.phase_a, smp.phase_b};
        // a zero detent count behaves as one
        limit = (detent_reg == 3'd0) ? 1 : int'(detent_reg);

        // the opening poll only latches the phase
        if (!enc_seen) begin
            enc_prev = ph;
            enc_seen = 1'b1;
        end else if (ph != enc_prev) begin
            // a jump across both bits is neither neighbour and adds nothing
            if (ph == cw_next(enc_prev)) begin
                step_sum++;
            end else if (ph == ccw_next(enc_prev)) begin
                step_sum--;
            end
            enc_prev = ph;
            // "at least": a sum left above a lowered count fires next change
            if (step_sum >= limit) begin
                res.detent_step = 2'sd1;
                detent_pos++;
                step_sum = 0;
            end else if (step_sum <= -limit) begin
                res.detent_step = -2'sd1;
                detent_pos--;
                step_sum = 0;
            end
        end

        back_fall    = back_lvl_q && !smp.back_in;
        confirm_fall = confirm_lvl_q && !smp.confirm_in;
        elapsed      = smp.time_ms - last_accept_ms;   // wraps mod 2^32

        if ((back_fall || confirm_fall) && elapsed < 32'(lockout_reg)) begin
            // levels not stored, so the edge comes round again
            res.press_held = 1'b1;
        end else begin
            back_lvl_q    = smp.back_in;
            confirm_lvl_q = smp.confirm_in;
            // back wins; a confirm edge in the same poll is dropped
            if (back_fall) begin
                back_hits++;
                res.back_event = 1'b1;
                last_accept_ms = smp.time_ms;
            end else if (confirm_fall) begin
                confirm_hits++;
                res.confirm_event = 1'b1;
                last_accept_ms = smp.time_ms;
            end
        end

        res.position      = detent_pos;
        res.back_count    = back_hits;
        res.confirm_count = confirm_hits;
        return res;
    endfunction

    function automatic qdbq_pkg::in_t poll(logic [1:0] ph, logic back, logic confirm,
                                           logic [31:0] ms);
        qdbq_pkg::in_t smp;
        smp.phase_a    = ph[1];
        smp.phase_b    = ph[0];
        smp.back_in    = back;
        smp.confirm_in = confirm;
        smp.time_ms    = ms;
        return smp;
    endfunction

    // Mostly a coherent rotation with button presses, plus some noise
    function automatic qdbq_pkg::in_t next_random_poll();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            if ($urandom_range(0, 9) == 0) spin_cw = !spin_cw;
            stim_phase = spin_cw ? cw_next(stim_phase) : ccw_next(stim_phase);
        end else if (pick < 85 && pick >= 75) begin
            stim_phase = ~stim_phase;                   // illegal jump
        end else if (pick >= 85) begin
            stim_phase = 2'($urandom);
        end
        if ($urandom_range(0, 5) == 0) stim_back = !stim_back;
        if ($urandom_range(0, 5) == 0) stim_confirm = !stim_confirm;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            stim_ms = $urandom();                       // anywhere, all bits
        end else if (pick < 5) begin
            stim_ms = stim_ms - $urandom_range(0, 64);  // time runs back
        end else begin
            stim_ms = stim_ms + $urandom_range(0, lockout_reg / 4 + 8);
        end
        return poll(stim_phase, stim_back, stim_confirm, stim_ms);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one poll transaction, with a random gap between bursts.
    // Called at a clock edge; leaves s_valid high for a follow-on poll.
    // ------------------------------------------------------------------------
    task automatic send_sample(qdbq_pkg::in_t smp);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_reports.push_back(qualify_sample(smp));
    endtask

    // Stops sending and waits for every owed report, then idles before returning
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register writes only go in with the block idle
    task automatic write_reg(qdbq_pkg::cfg_index_t idx, qdbq_pkg::cfg_data_t val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            qdbq_pkg::CFG_LOCKOUT_MS:       lockout_reg = val[9:0];
            qdbq_pkg::CFG_STEPS_PER_DETENT: detent_reg  = val[2:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready pattern per mode, overridden by a counted hold-off
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_tick++;
        if (holds_started != hold_requests) begin
            holds_started++;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_ready <= 1'b1;
                RX_MOSTLY:  m_ready <= ($urandom_range(0, 99) < 70);
                RX_PATTERN: m_ready <= ((rx_tick % 11) > 3);
                default:    m_ready <= ($urandom_range(0, 99) < 25);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Report monitor: each report transaction against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        qdbq_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t: report with no poll outstanding, actual %h",
                         $time, m_data);
            end else begin
                want = pending_reports.pop_front();
                compare_field("detent_step", 32'(want.detent_step),
                              32'(m_data.detent_step));
                compare_field("position", want.position, m_data.position);
                compare_field("back_event", 32'(want.back_event),
                              32'(m_data.back_event));
                compare_field("confirm_event", 32'(want.confirm_event),
                              32'(m_data.confirm_event));
                compare_field("back_count", 32'(want.back_count),
                              32'(m_data.back_count));
                compare_field("confirm_count", 32'(want.confirm_count),
                              32'(m_data.confirm_count));
                compare_field("press_held", 32'(want.press_held),
                              32'(m_data.press_held));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: opening poll latches phase, early press held by the
    // lockout against time zero, one clockwise detent, illegal jump, repeat
    task automatic test_reset_lockout_and_rotation();
        rx_mode = RX_MOSTLY;
        send_sample(poll(2'b00, 1'b1, 1'b1, 32'd5));
        send_sample(poll(2'b10, 1'b0, 1'b1, 32'd10));     // held
        send_sample(poll(2'b11, 1'b0, 1'b1, 32'd120));    // exactly the lockout
        send_sample(poll(2'b01, 1'b1, 1'b1, 32'd130));
        send_sample(poll(2'b00, 1'b1, 1'b1, 32'd131));    // fourth step: detent
        send_sample(poll(2'b11, 1'b1, 1'b1, 32'd132));    // across both bits
        send_sample(poll(2'b11, 1'b1, 1'b1, 32'd133));
        settle();
    endtask

    // Both fall together: back taken, confirm lost; then confirm alone
    task automatic test_both_buttons();
        rx_mode = RX_PATTERN;
        send_sample(poll(2'b11, 1'b1, 1'b1, 32'd1000));
        send_sample(poll(2'b11, 1'b0, 1'b0, 32'd1000));
        send_sample(poll(2'b11, 1'b1, 1'b1, 32'd1010));
        send_sample(poll(2'b11, 1'b1, 1'b0, 32'd1050));   // held
        send_sample(poll(2'b11, 1'b1, 1'b0, 32'd1120));
        settle();
    endtask

    // Elapsed time taken across the 32-bit wrap
    task automatic test_time_wrap();
        rx_mode = RX_SPARSE;
        send_sample(poll(2'b11, 1'b1, 1'b1, 32'hFFFF_FFF0));
        send_sample(poll(2'b11, 1'b0, 1'b1, 32'hFFFF_FFF8));
        send_sample(poll(2'b11, 1'b1, 1'b1, 32'h0000_0010));
        send_sample(poll(2'b11, 1'b0, 1'b1, 32'h0000_0020)); // 40 ms on: held
        send_sample(poll(2'b11, 1'b0, 1'b1, 32'h0000_0070)); // 120 ms on
        settle();
    endtask

    // Register extremes, zero detent count and a lowered detent count
    task automatic test_register_extremes();
        rx_mode = RX_ALWAYS;
        write_reg(qdbq_pkg::CFG_LOCKOUT_MS, 10'd0);
        write_reg(qdbq_pkg::CFG_STEPS_PER_DETENT, 10'd0);
        send_sample(poll(2'b10, 1'b1, 1'b1, 32'h70));     // ccw, acts as count 1
        send_sample(poll(2'b10, 1'b0, 1'b1, 32'h70));     // zero elapsed, no lockout
        send_sample(poll(2'b00, 1'b1, 1'b0, 32'h70));

        write_reg(qdbq_pkg::CFG_LOCKOUT_MS, 10'd1023);
        write_reg(qdbq_pkg::CFG_STEPS_PER_DETENT, 10'd7);
        send_sample(poll(2'b10, 1'b1, 1'b1, 32'h80));
        send_sample(poll(2'b11, 1'b1, 1'b1, 32'h81));
        send_sample(poll(2'b01, 1'b1, 1'b1, 32'h82));
        send_sample(poll(2'b00, 1'b1, 1'b1, 32'h83));
        send_sample(poll(2'b10, 1'b1, 1'b1, 32'h84));     // sum of five, no detent

        write_reg(qdbq_pkg::CFG_STEPS_PER_DETENT, 10'd2);
        send_sample(poll(2'b11, 1'b1, 1'b1, 32'h85));     // six against two: fires
        send_sample(poll(2'b11, 1'b0, 1'b1, 32'h70 + 32'd1022));   // held
        send_sample(poll(2'b11, 1'b0, 1'b1, 32'h70 + 32'd1023));
        settle();
        stim_phase = 2'b11;
        stim_ms    = 32'h70 + 32'd1023;
        stim_back  = 1'b0;
    endtask

    // Long output stall with the sender pushing back-to-back
    task automatic test_output_backpressure();
        write_reg(qdbq_pkg::CFG_LOCKOUT_MS, 10'(qdbq_pkg::LOCKOUT_MS_RST));
        write_reg(qdbq_pkg::CFG_STEPS_PER_DETENT, 10'(qdbq_pkg::STEPS_PER_DETENT_RST));
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b0;
        hold_requests++;
        repeat (BACKPRESSURE_POLLS) send_sample(next_random_poll());
        settle();
        gaps_on = 1'b1;
    endtask

    // Random soak across several register settings
    task automatic test_random_polls();
        qdbq_pkg::cfg_data_t lock_v;
        qdbq_pkg::cfg_data_t steps_v;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: begin
                    lock_v  = 10'd0;
                    steps_v = 10'd1;
                end
                1: begin
                    lock_v  = 10'd1023;
                    steps_v = 10'd7;
                end
                2: begin
                    lock_v  = 10'd120;
                    steps_v = 10'd4;
                end
                3: begin
                    lock_v  = 10'($urandom_range(0, 1023));
                    steps_v = 10'($urandom_range(0, 7));
                end
                4: begin
                    lock_v  = 10'd7;
                    steps_v = 10'd0;
                end
                default: begin
                    lock_v  = 10'($urandom_range(0, 300));
                    steps_v = 10'd2;
                end
            endcase
            write_reg(qdbq_pkg::CFG_LOCKOUT_MS, lock_v);
            write_reg(qdbq_pkg::CFG_STEPS_PER_DETENT, steps_v);
            rx_mode = rx_mode_t'(k % 4);
            gaps_on = (k % 3) != 2;     // every third setting runs flat out
            repeat (RANDOM_POLLS_PER_SETTING) send_sample(next_random_poll());
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_qualifier_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_lockout_and_rotation();
        test_both_buttons();
        test_time_wrap();
        test_register_extremes();
        test_output_backpressure();
        test_random_polls();

        settle();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/qdbq_pkg.sv
rtl/core/quadrature_detent_and_button_qualifier_core.sv
rtl/core/qdbq_checker.sv
sim/tb.sv
